// ===== rtl/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants for the set-associative cache directory.
// ----------------------------------------------------------------------------
package sac_pkg;

  // Default sizing
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;

  // Field widths
  localparam int ADDR_W   = 64;
  localparam int TAG_W    = 64;
  localparam int AGE_W    = 3;
  localparam int AGE_MAX  = 7;
  localparam int CNT_W    = 32;
  localparam int OUTC_W   = 2;
  localparam int WAYO_W   = 3;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;
  localparam int SBITS_W   = 3;
  localparam int OBITS_W   = 6;
  localparam int NWAYS_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

  localparam logic [SBITS_W-1:0] SBITS_RST = 3'd0;
  localparam logic [OBITS_W-1:0] OBITS_RST = 6'd4;
  localparam logic [NWAYS_W-1:0] NWAYS_RST = 4'd1;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // write one cleared set row
    logic accept;  // take an item, start set read
    logic commit;  // write back set row, update counters, load result
  } sac_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // clearing pass is on its last row
  } sac_sts_t;

endpackage

// ===== rtl/sac_ram.sv =====
// ----------------------------------------------------------------------------
// sac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sac_ctrl.sv =====
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer: clearing pass after reset, accept, look-up/commit, result hold.
// ----------------------------------------------------------------------------
module sac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sac_pkg::sac_sts_t sts,
  output sac_pkg::sac_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Commands
  always_comb begin
    cmd.clear  = (state_r == ST_CLEAR);
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    // result slot must be empty or draining this cycle
    cmd.commit = (state_r == ST_LOOK) && (!out_valid_r || out_ready);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (cmd.accept)   state_nxt = ST_LOOK;
      ST_LOOK:  if (cmd.commit)   state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Result valid flag
  always_comb begin
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/sac_dp.sv =====
// ----------------------------------------------------------------------------
// sac_dp
// Datapath: address split, set RAM, tag compare, LRU update, counters.
// ----------------------------------------------------------------------------
module sac_dp #(
  parameter int MAX_SET_BITS = sac_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sac_pkg::MAX_WAYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sac_pkg::sac_cmd_t                 cmd,
  output sac_pkg::sac_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sac_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  logic [sac_pkg::ADDR_W-1:0]        in_address,
  output logic [sac_pkg::OUTC_W-1:0]        out_outcome,
  output logic [sac_pkg::WAYO_W-1:0]        out_way_used,
  output logic [sac_pkg::CNT_W-1:0]         out_hit_total,
  output logic [sac_pkg::CNT_W-1:0]         out_miss_total,
  output logic [sac_pkg::CNT_W-1:0]         out_evict_total
);

  localparam int NSETS   = 1 << MAX_SET_BITS;
  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W    = $clog2(MAX_WAYS + 1) + 1;
  localparam int AGE_W   = sac_pkg::AGE_W;
  localparam int TAG_W   = sac_pkg::TAG_W;
  localparam int ENTRY_W = 1 + AGE_W + TAG_W;
  localparam int ROW_W   = MAX_WAYS * ENTRY_W;
  localparam int LIM_W   = AGE_W + 1;
  localparam int SH_W    = sac_pkg::OBITS_W + 1;

  // Configuration registers
  logic [sac_pkg::SBITS_W-1:0] cfg_sbits_r;
  logic [sac_pkg::OBITS_W-1:0] cfg_obits_r;
  logic [sac_pkg::NWAYS_W-1:0] cfg_nways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sbits_r <= sac_pkg::SBITS_RST;
      cfg_obits_r <= sac_pkg::OBITS_RST;
      cfg_nways_r <= sac_pkg::NWAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sac_pkg::REG_SET_BITS:    cfg_sbits_r <= cfg_wdata[sac_pkg::SBITS_W-1:0];
        sac_pkg::REG_OFFSET_BITS: cfg_obits_r <= cfg_wdata[sac_pkg::OBITS_W-1:0];
        sac_pkg::REG_WAYS:        cfg_nways_r <= cfg_wdata[sac_pkg::NWAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective set bits and associativity
  logic [sac_pkg::SBITS_W-1:0] sbits;
  logic [NW_W-1:0]             nways;

  always_comb begin
    if (int'(cfg_sbits_r) > MAX_SET_BITS) begin
      sbits = sac_pkg::SBITS_W'(MAX_SET_BITS);
    end else begin
      sbits = cfg_sbits_r;
    end
    priority if (cfg_nways_r == '0) begin
      nways = NW_W'(1);
    end else if (int'(cfg_nways_r) > MAX_WAYS) begin
      nways = NW_W'(MAX_WAYS);
    end else begin
      nways = NW_W'(cfg_nways_r);
    end
  end

  // Address split at accept
  logic [sac_pkg::ADDR_W-1:0] addr_sh;
  logic [SET_W-1:0]           set_mask;
  logic [SET_W-1:0]           set_c;
  logic [SH_W-1:0]            tag_shift;
  logic [TAG_W-1:0]           tag_c;

  always_comb begin
    addr_sh   = in_address >> cfg_obits_r;
    set_mask  = ~({SET_W{1'b1}} << sbits);
    set_c     = addr_sh[SET_W-1:0] & set_mask;
    tag_shift = SH_W'(sbits) + SH_W'(cfg_obits_r);
    // shift of 64 or more yields zero
    tag_c     = in_address >> tag_shift;
  end

  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_r <= set_c;
      tag_r <= tag_c;
    end
  end

  // Clearing pass counter
  logic [SET_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == SET_W'(NSETS - 1));

  // Set RAM: one row per set, entry = {valid, age, tag}
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] new_row;

  assign ram_we    = cmd.clear || cmd.commit;
  assign ram_waddr = cmd.clear ? clr_cnt_r : set_r;
  assign ram_wdata = cmd.clear ? '0 : new_row;

  sac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NSETS),
    .AW    (SET_W)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (set_c),
    .rdata (ram_rdata)
  );

  // Look-up on the row read
  logic [MAX_WAYS-1:0] way_vld;
  logic [AGE_W-1:0]    way_age [MAX_WAYS];
  logic [TAG_W-1:0]    way_tag [MAX_WAYS];
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] empty_vec;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    empty_way;
  logic [WAY_W-1:0]    vic_way;
  logic [AGE_W-1:0]    best_age;
  logic                hit;
  logic                has_empty;
  logic [WAY_W-1:0]    sel_way;
  logic [LIM_W-1:0]    limit;
  logic [sac_pkg::OUTC_W-1:0] outcome_c;

  always_comb begin
    for (int k = 0; k < MAX_WAYS; k++) begin
      way_vld[k]   = ram_rdata[k*ENTRY_W + AGE_W + TAG_W];
      way_age[k]   = ram_rdata[k*ENTRY_W + TAG_W +: AGE_W];
      way_tag[k]   = ram_rdata[k*ENTRY_W +: TAG_W];
      in_use[k]    = NW_W'(k) < nways;
      hit_vec[k]   = in_use[k] && way_vld[k] && (way_tag[k] == tag_r);
      empty_vec[k] = in_use[k] && !way_vld[k];
    end

    // lowest-numbered hit and empty way
    hit_way   = '0;
    empty_way = '0;
    for (int k = MAX_WAYS - 1; k >= 0; k--) begin
      if (hit_vec[k])   hit_way   = WAY_W'(k);
      if (empty_vec[k]) empty_way = WAY_W'(k);
    end
    hit       = |hit_vec;
    has_empty = |empty_vec;

    // LRU victim: oldest way, lowest index on a tie
    best_age = '0;
    vic_way  = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (in_use[k] && (way_age[k] > best_age)) begin
        best_age = way_age[k];
        vic_way  = WAY_W'(k);
      end
    end

    priority if (hit) begin
      sel_way   = hit_way;
      outcome_c = sac_pkg::OUTC_HIT;
      limit     = {1'b0, way_age[hit_way]};
    end else if (has_empty) begin
      sel_way   = empty_way;
      outcome_c = sac_pkg::OUTC_FILL;
      limit     = LIM_W'(sac_pkg::AGE_MAX + 1);
    end else begin
      sel_way   = vic_way;
      outcome_c = sac_pkg::OUTC_EVICT;
      limit     = LIM_W'(sac_pkg::AGE_MAX + 1);
    end
  end

  // Row write-back with age update
  always_comb begin
    new_row = ram_rdata;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (WAY_W'(k) == sel_way) begin
        new_row[k*ENTRY_W +: ENTRY_W] = {1'b1, {AGE_W{1'b0}}, tag_r};
      end else if (in_use[k] && way_vld[k] && ({1'b0, way_age[k]} < limit)
                   && (way_age[k] != AGE_W'(sac_pkg::AGE_MAX))) begin
        new_row[k*ENTRY_W + TAG_W +: AGE_W] = way_age[k] + AGE_W'(1);
      end
    end
  end

  // Counters and result payload; counters only move on commit, when the
  // result slot is being reloaded, so they drive the result directly.
  logic [sac_pkg::CNT_W-1:0]  hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [sac_pkg::CNT_W-1:0]  hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;
  logic [sac_pkg::OUTC_W-1:0] outcome_r;
  logic [sac_pkg::WAYO_W-1:0] way_r;

  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    if (cmd.commit) begin
      if (hit) begin
        hit_cnt_nxt = hit_cnt_r + sac_pkg::CNT_W'(1);
      end else begin
        miss_cnt_nxt = miss_cnt_r + sac_pkg::CNT_W'(1);
      end
      if (!hit && !has_empty) begin
        evict_cnt_nxt = evict_cnt_r + sac_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      outcome_r <= outcome_c;
      way_r     <= sac_pkg::WAYO_W'(sel_way);
    end
  end

  assign out_outcome     = outcome_r;
  assign out_way_used    = way_r;
  assign out_hit_total   = hit_cnt_r;
  assign out_miss_total  = miss_cnt_r;
  assign out_evict_total = evict_cnt_r;

endmodule

// ===== rtl/set_assoc_cache_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup
// Set-associative cache directory with LRU replacement and hit/miss/evict
// counters.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | in_address
//   out     | output    | out_valid / out_ready| out_outcome, out_way_used,
//           |           |                      | out_hit_total, out_miss_total,
//           |           |                      | out_evict_total
//   cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// An item passes through accept (address split, set row read from the set
// RAM) and commit (tag compare, LRU update, row write-back). The single RAM
// row per set means a new item is taken only in the cycle after commit.
// After reset a clearing pass writes all 2**MAX_SET_BITS set rows (64 by
// default) with in_ready low; configuration writes are taken.
// A result waiting on out_ready does not block the next accept; commit of
// that next item waits until the result slot drains.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup #(
  parameter int MAX_SET_BITS = sac_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sac_pkg::MAX_WAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sac_pkg::ADDR_W-1:0]    in_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sac_pkg::OUTC_W-1:0]    out_outcome,
  output logic [sac_pkg::WAYO_W-1:0]    out_way_used,
  output logic [sac_pkg::CNT_W-1:0]     out_hit_total,
  output logic [sac_pkg::CNT_W-1:0]     out_miss_total,
  output logic [sac_pkg::CNT_W-1:0]     out_evict_total,
  input  logic                          cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sac_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  sac_pkg::sac_cmd_t cmd;
  sac_pkg::sac_sts_t sts;

  sac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sac_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_address      (in_address),
    .out_outcome     (out_outcome),
    .out_way_used    (out_way_used),
    .out_hit_total   (out_hit_total),
    .out_miss_total  (out_miss_total),
    .out_evict_total (out_evict_total)
  );

  // No item is taken while the clearing pass runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && cmd.clear))
    else $error("item accepted during clearing pass");

  // An accepted item blocks further accepts while it is in look-up
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted during look-up");

  // Commit always presents a result
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without result");

  // Every commit moves the hit or the miss count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ((out_hit_total + out_miss_total) ==
                    ($past(out_hit_total) + $past(out_miss_total) + 32'd1)))
    else $error("hit/miss counters out of step");

endmodule
